FILE: sv/fgt_pkg.sv
// Shared types and constants for the fuzzy gain tuner.
// Depends on nothing; used by fuzzy_gain_tuner.
`default_nettype none

package fgt_pkg;

    // One input word: control error and its rate of change, both Q7.8.
    typedef struct packed {
        logic signed [15:0] error_value;
        logic signed [15:0] error_change;
    } in_word_t;

    // One result word: Q3.12 gain correction and the forced-zero flag.
    typedef struct packed {
        logic signed [15:0] gain_delta;
        logic               no_rule_fired;
    } out_word_t;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 45;
    localparam int RULE_LOW_W  = 45;
    localparam int RULE_HIGH_W = 30;
    localparam int NUM_SETS    = 5;
    localparam int LOW_ROWS    = 3;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_ERROR_LOW   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ERROR_HIGH  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CHANGE_LOW  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CHANGE_HIGH = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_LOW    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_HIGH   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_RULE_LOW    = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_RULE_HIGH   = 3'd7;

    // Values after reset.
    localparam logic signed [15:0] RST_ERROR_LOW   = -16'sd12800;
    localparam logic signed [15:0] RST_ERROR_HIGH  = 16'sd12800;
    localparam logic signed [15:0] RST_CHANGE_LOW  = -16'sd2560;
    localparam logic signed [15:0] RST_CHANGE_HIGH = 16'sd2560;
    localparam logic signed [15:0] RST_GAIN_LOW    = -16'sd2048;
    localparam logic signed [15:0] RST_GAIN_HIGH   = 16'sd2048;
    localparam logic [RULE_LOW_W-1:0]  RST_RULE_LOW  = 45'd19388093221146;
    localparam logic [RULE_HIGH_W-1:0] RST_RULE_HIGH = 30'd285226048;

endpackage

`default_nettype wire

FILE: sv/fgt_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Self-contained; used by fuzzy_gain_tuner.
`default_nettype none

module fgt_div #(
    parameter int NW = 30,
    parameter int DW = 16
) (
    input  logic          clk,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [NW-1:0] quo
);

    logic [DW-1:0] rem_reg [NW];
    logic [NW-1:0] num_reg [NW];
    logic [NW-1:0] quo_reg [NW];
    logic [DW-1:0] den_reg [NW];

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic [DW-1:0] rem_in;
        logic [NW-1:0] num_in;
        logic [NW-1:0] quo_in;
        logic [DW-1:0] den_in;
        logic [DW:0]   trial;
        logic          fits;

        if (k == 0) begin : g_first
            assign rem_in = '0;
            assign num_in = num;
            assign quo_in = '0;
            assign den_in = den;
        end else begin : g_next
            assign rem_in = rem_reg[k-1];
            assign num_in = num_reg[k-1];
            assign quo_in = quo_reg[k-1];
            assign den_in = den_reg[k-1];
        end

        // Bring down the next dividend bit and try one subtraction.
        assign trial = {rem_in, num_in[NW-1]};
        assign fits  = (trial >= {1'b0, den_in});

        always_ff @(posedge clk)
        begin
            rem_reg[k] <= fits ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];
            num_reg[k] <= num_in << 1;
            quo_reg[k] <= {quo_in[NW-2:0], fits};
            den_reg[k] <= den_in;
        end
    end

    assign quo = quo_reg[NW-1];

endmodule

`default_nettype wire

FILE: sv/fuzzy_gain_tuner.sv
// Fuzzy gain tuner top level: a pipelined 5x5 Mamdani inference datapath.
// Depends on fgt_pkg (types, register indexes, reset values) and fgt_div.
//
//  Channel   Signals                                 Direction  Handshake
//  -------   -------------------------------------   ---------  ----------------------
//  input     start, busy, sample                     in         start && !busy
//  result    done, result                            out        done, one cycle, no hold
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data  in      cfg_valid && cfg_ready
//
// A word is accepted in every cycle; busy never rises. The pipeline holds two
// pipelined dividers, one bit per stage: the input scaling divider
// (FRAC_BITS + 18 stages) and the centroid divider (FRAC_BITS + 22 stages).
// Reset clears the valid bits and loads the register reset values. The
// receiver cannot stall, so nothing in the pipeline stalls.
`default_nettype none

module fuzzy_gain_tuner
    import fgt_pkg::*;
#(
    parameter int FRAC_BITS = 12
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  in_word_t               sample,
    output logic                   done,
    output out_word_t              result,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // Input scaling: quotient of |v - low| * 4 * ONE by the span.
    localparam int NW1 = FRAC_BITS + 18;
    localparam int SW  = FRAC_BITS + 21;     // signed normalized value
    localparam int MW  = FRAC_BITS + 1;      // membership, 0..ONE
    localparam int WKW = FRAC_BITS + 6;      // weighted sum, below 32 * ONE
    localparam int DNW = FRAC_BITS + 4;      // membership total, at most 5 * ONE
    localparam int NW2 = WKW + 16;           // product of weighted sum and gain span
    localparam int DW2 = FRAC_BITS + 6;      // four times the total
    localparam logic signed [SW-1:0] ONE_S = SW'(1) <<< FRAC_BITS;

    // ---------------- configuration registers ----------------
    logic signed [15:0]     error_low_reg, error_high_reg;
    logic signed [15:0]     change_low_reg, change_high_reg;
    logic signed [15:0]     gain_low_reg, gain_high_reg;
    logic [RULE_LOW_W-1:0]  rule_low_reg;
    logic [RULE_HIGH_W-1:0] rule_high_reg;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_low_reg   <= RST_ERROR_LOW;
            error_high_reg  <= RST_ERROR_HIGH;
            change_low_reg  <= RST_CHANGE_LOW;
            change_high_reg <= RST_CHANGE_HIGH;
            gain_low_reg    <= RST_GAIN_LOW;
            gain_high_reg   <= RST_GAIN_HIGH;
            rule_low_reg    <= RST_RULE_LOW;
            rule_high_reg   <= RST_RULE_HIGH;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_ERROR_LOW:   error_low_reg   <= cfg_data[15:0];
                REG_ERROR_HIGH:  error_high_reg  <= cfg_data[15:0];
                REG_CHANGE_LOW:  change_low_reg  <= cfg_data[15:0];
                REG_CHANGE_HIGH: change_high_reg <= cfg_data[15:0];
                REG_GAIN_LOW:    gain_low_reg    <= cfg_data[15:0];
                REG_GAIN_HIGH:   gain_high_reg   <= cfg_data[15:0];
                REG_RULE_LOW:    rule_low_reg    <= cfg_data[RULE_LOW_W-1:0];
                REG_RULE_HIGH:   rule_high_reg   <= cfg_data[RULE_HIGH_W-1:0];
                default:         ;
            endcase
        end
    end

    // Spans. The user must change the registers only while the pipeline is empty
    // (the block does not enforce this), so every stage reads them directly.
    logic signed [16:0] error_span, change_span, gain_span;
    logic               span_bad;

    assign error_span  = 17'(error_high_reg)  - 17'(error_low_reg);
    assign change_span = 17'(change_high_reg) - 17'(change_low_reg);
    assign gain_span   = 17'(gain_high_reg)   - 17'(gain_low_reg);
    assign span_bad    = (error_span <= 0) || (change_span <= 0) || (gain_span <= 0);

    // ---------------- stage 0: offsets from the range bottom ----------------
    logic signed [16:0] e_off, c_off;
    logic               v0_reg;
    logic [15:0]        e_mag_reg, c_mag_reg;
    logic               e_neg_reg, c_neg_reg;

    assign e_off = 17'(sample.error_value)  - 17'(error_low_reg);
    assign c_off = 17'(sample.error_change) - 17'(change_low_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else
            v0_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        e_neg_reg <= e_off[16];
        c_neg_reg <= c_off[16];
        e_mag_reg <= e_off[16] ? 16'(-e_off) : e_off[15:0];
        c_mag_reg <= c_off[16] ? 16'(-c_off) : c_off[15:0];
    end

    // ---------------- scaling dividers ----------------
    logic [NW1-1:0] e_quo, c_quo;

    fgt_div #(.NW(NW1), .DW(16)) u_div_error (
        .clk (clk),
        .num ({e_mag_reg, (FRAC_BITS + 2)'(0)}),
        .den (error_span[15:0]),
        .quo (e_quo)
    );

    fgt_div #(.NW(NW1), .DW(16)) u_div_change (
        .clk (clk),
        .num ({c_mag_reg, (FRAC_BITS + 2)'(0)}),
        .den (change_span[15:0]),
        .quo (c_quo)
    );

    // Valid bits and signs travel beside the divider.
    logic v1_line_reg  [NW1];
    logic en_line_reg  [NW1];
    logic cn_line_reg  [NW1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NW1; k++)
                v1_line_reg[k] <= 1'b0;
        end
        else
        begin
            v1_line_reg[0] <= v0_reg;
            for (int k = 1; k < NW1; k++)
                v1_line_reg[k] <= v1_line_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        en_line_reg[0] <= e_neg_reg;
        cn_line_reg[0] <= c_neg_reg;
        for (int k = 1; k < NW1; k++)
        begin
            en_line_reg[k] <= en_line_reg[k-1];
            cn_line_reg[k] <= cn_line_reg[k-1];
        end
    end

    // ---------------- stage A: triangular memberships ----------------
    logic signed [SW-1:0] e_norm, c_norm;
    logic [MW-1:0]        e_mu_next [NUM_SETS];
    logic [MW-1:0]        c_mu_next [NUM_SETS];
    logic [MW-1:0]        e_mu_reg  [NUM_SETS];
    logic [MW-1:0]        c_mu_reg  [NUM_SETS];
    logic                 va_reg;

    // Division truncates toward zero, so a negative offset negates the quotient.
    assign e_norm = (en_line_reg[NW1-1] ? -SW'(e_quo) : SW'(e_quo)) - (ONE_S <<< 1);
    assign c_norm = (cn_line_reg[NW1-1] ? -SW'(c_quo) : SW'(c_quo)) - (ONE_S <<< 1);

    always_comb
    begin
        logic signed [SW-1:0] ed, cd;
        for (int k = 0; k < NUM_SETS; k++)
        begin
            ed = e_norm - SW'(k - 2) * ONE_S;
            cd = c_norm - SW'(k - 2) * ONE_S;
            if (ed < 0)
                ed = -ed;
            if (cd < 0)
                cd = -cd;
            e_mu_next[k] = (ed >= ONE_S) ? '0 : MW'(ONE_S - ed);
            c_mu_next[k] = (cd >= ONE_S) ? '0 : MW'(ONE_S - cd);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            va_reg <= 1'b0;
        else
            va_reg <= v1_line_reg[NW1-1];
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NUM_SETS; k++)
        begin
            e_mu_reg[k] <= e_mu_next[k];
            c_mu_reg[k] <= c_mu_next[k];
        end
    end

    // ---------------- stage B: rule activations (min) ----------------
    logic [MW-1:0] act_reg [NUM_SETS][NUM_SETS];
    logic          vb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vb_reg <= 1'b0;
        else
            vb_reg <= va_reg;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_SETS; i++)
            for (int j = 0; j < NUM_SETS; j++)
                act_reg[i][j] <= (e_mu_reg[i] < c_mu_reg[j]) ? e_mu_reg[i] : c_mu_reg[j];
    end

    // ---------------- stage C: per-row max for each output set ----------------
    logic [2:0]    rule_code [NUM_SETS][NUM_SETS];
    logic [MW-1:0] row_max_next [NUM_SETS][NUM_SETS];
    logic [MW-1:0] row_max_reg  [NUM_SETS][NUM_SETS];
    logic          vc_reg;

    always_comb
    begin
        for (int i = 0; i < NUM_SETS; i++)
            for (int j = 0; j < NUM_SETS; j++)
                if (i < LOW_ROWS)
                    rule_code[i][j] = rule_low_reg[3*(5*i+j) +: 3];
                else
                    rule_code[i][j] = rule_high_reg[3*(5*(i-LOW_ROWS)+j) +: 3];
    end

    // Codes 5..7 name no output set and never match.
    always_comb
    begin
        for (int i = 0; i < NUM_SETS; i++)
            for (int s = 0; s < NUM_SETS; s++)
            begin
                row_max_next[i][s] = '0;
                for (int j = 0; j < NUM_SETS; j++)
                    if (rule_code[i][j] == 3'(s) && act_reg[i][j] > row_max_next[i][s])
                        row_max_next[i][s] = act_reg[i][j];
            end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vc_reg <= 1'b0;
        else
            vc_reg <= vb_reg;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_SETS; i++)
            for (int s = 0; s < NUM_SETS; s++)
                row_max_reg[i][s] <= row_max_next[i][s];
    end

    // ---------------- stage D: output set strengths (max over rows) ----------------
    logic [MW-1:0] omu_next [NUM_SETS];
    logic [MW-1:0] omu_reg  [NUM_SETS];
    logic          vd_reg;

    always_comb
    begin
        for (int s = 0; s < NUM_SETS; s++)
        begin
            omu_next[s] = '0;
            for (int i = 0; i < NUM_SETS; i++)
                if (row_max_reg[i][s] > omu_next[s])
                    omu_next[s] = row_max_reg[i][s];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vd_reg <= 1'b0;
        else
            vd_reg <= vc_reg;
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < NUM_SETS; s++)
            omu_reg[s] <= omu_next[s];
    end

    // ---------------- stage E: centroid sums ----------------
    logic [DNW-1:0] den_next, den_reg;
    logic [WKW-1:0] wk_next, wk_reg;
    logic           ve_reg;

    always_comb
    begin
        den_next = '0;
        wk_next  = '0;
        for (int s = 0; s < NUM_SETS; s++)
        begin
            den_next = den_next + DNW'(omu_reg[s]);
            wk_next  = wk_next + WKW'(omu_reg[s]) * WKW'(s);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ve_reg <= 1'b0;
        else
            ve_reg <= vd_reg;
    end

    always_ff @(posedge clk)
    begin
        den_reg <= den_next;
        wk_reg  <= wk_next;
    end

    // ---------------- stage F: scale by the gain span ----------------
    logic [NW2-1:0] prod_reg;
    logic [DW2-1:0] div4_reg;
    logic           zero_reg;
    logic           vf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vf_reg <= 1'b0;
        else
            vf_reg <= ve_reg;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= NW2'(wk_reg) * NW2'(gain_span[15:0]);
        div4_reg <= DW2'(den_reg) << 2;
        zero_reg <= (den_reg == '0);
    end

    // ---------------- centroid divider ----------------
    logic [NW2-1:0] g_quo;

    fgt_div #(.NW(NW2), .DW(DW2)) u_div_centroid (
        .clk (clk),
        .num (prod_reg),
        .den (div4_reg),
        .quo (g_quo)
    );

    logic v2_line_reg [NW2];
    logic z_line_reg  [NW2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NW2; k++)
                v2_line_reg[k] <= 1'b0;
        end
        else
        begin
            v2_line_reg[0] <= vf_reg;
            for (int k = 1; k < NW2; k++)
                v2_line_reg[k] <= v2_line_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        z_line_reg[0] <= zero_reg;
        for (int k = 1; k < NW2; k++)
            z_line_reg[k] <= z_line_reg[k-1];
    end

    // ---------------- output stage: offset, saturate, flag ----------------
    // The quotient never exceeds the gain span, so 17 bits hold it.
    logic signed [17:0] gain_sum;
    logic               forced_zero;
    out_word_t          result_next, result_reg;
    logic               done_reg;

    assign gain_sum    = 18'(gain_low_reg) + $signed({1'b0, g_quo[16:0]});
    assign forced_zero = span_bad || z_line_reg[NW2-1];

    always_comb
    begin
        result_next.no_rule_fired = forced_zero;
        if (forced_zero)
            result_next.gain_delta = '0;
        else if (gain_sum > 18'sd32767)
            result_next.gain_delta = 16'sh7fff;
        else
            result_next.gain_delta = gain_sum[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= v2_line_reg[NW2-1];
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire
